// File: hw/rtl/gha_pkg.sv
// Shared types, constants and the helper function of the generational handle allocator.
package gha_pkg;

    // Sizes of the slot table and of the item fields.
    localparam int SLOT_COUNT = 1024;
    localparam int IDX_W      = $clog2(SLOT_COUNT);
    localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
    localparam int GEN_W      = 16;
    localparam int MASK_W     = 64;
    localparam int COMP_TYPES = 64;
    localparam int CTYPE_W    = 6;

    // The internal live count is one bit wider than the response field so that it never wraps,
    // even when a slot is queued twice through a handle that names a freed slot.
    localparam int LIVE_W     = CNT_W + 1;

    // Presence bits that a slot can hold, and the first component type that is out of range.
    localparam logic [MASK_W-1:0]  COMP_MASK  = {MASK_W{1'b1}} >> (MASK_W - COMP_TYPES);
    localparam logic [CTYPE_W:0]   COMP_LIMIT = (CTYPE_W + 1)'(COMP_TYPES);

    // A freshly grown slot starts at this generation.
    localparam logic [GEN_W-1:0]   GEN_FIRST  = GEN_W'(1);

    // Queue select bit on top of the shared queue memory address.
    localparam logic Q_FREE = 1'b0;
    localparam logic Q_PEND = 1'b1;

    typedef enum logic [2:0] {
        ACT_CREATE      = 3'd0,
        ACT_ADD         = 3'd1,
        ACT_DESTROY     = 3'd2,
        ACT_DESTROY_NOW = 3'd3,
        ACT_REFRESH     = 3'd4,
        ACT_CHECK       = 3'd5,
        ACT_CLEAR       = 3'd6
    } t_action;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_STALE  = 2'd1,
        ST_NOFREE = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP_FREE,
        S_EXEC,
        S_REF_RD,
        S_REF_WR,
        S_CLR_RD,
        S_CLR_WR
    } t_state;

    typedef struct packed {
        t_action               action;
        logic [IDX_W-1:0]      slot_index;
        logic [GEN_W-1:0]      slot_generation;
        logic [MASK_W-1:0]     initial_mask;
        logic [CTYPE_W-1:0]    component_type;
    } t_req;

    typedef struct packed {
        t_status               status;
        logic [IDX_W-1:0]      out_index;
        logic [GEN_W-1:0]      out_generation;
        logic                  handle_valid;
        logic [CNT_W-1:0]      live_count;
    } t_rsp;

    // One entry of the slot table.
    typedef struct packed {
        logic [GEN_W-1:0]      gen;
        logic [MASK_W-1:0]     mask;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

    // Next generation of a slot; zero is never used, so the count wraps to one.
    function automatic logic [GEN_W-1:0] gen_next(input logic [GEN_W-1:0] g);
        logic [GEN_W-1:0] n;
        n = g + GEN_W'(1);
        return (n == '0) ? GEN_FIRST : n;
    endfunction

endpackage

// File: hw/rtl/gha_ram.sv
// Simple dual-port synchronous RAM with one write port and one registered read port.
module gha_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 80
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hw/rtl/generational_handle_allocator.sv
// Top level of the generational handle allocator: sequencer around the slot and queue memories.
// Add, destroy, check and fresh-slot create go straight to execute; a free-list create pops first.
// Refresh moves each pending slot to the free list by one queue read and one queue write;
// clear gives each grown slot one read and one write-back of the slot memory.
// The response sits in an output register, so a new request enters while it waits to be taken.
// Reset clears the control state; the slot fill count stands in for table init.
module generational_handle_allocator (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_stall,
    input  gha_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_stall,
    output gha_pkg::t_rsp o_rsp
);

    localparam int IDX_W  = gha_pkg::IDX_W;
    localparam int CNT_W  = gha_pkg::CNT_W;
    localparam int GEN_W  = gha_pkg::GEN_W;
    localparam int LIVE_W = gha_pkg::LIVE_W;

    // Control state.
    gha_pkg::t_state      r_state, n_state;
    logic [CNT_W-1:0]     r_siu, n_siu;
    logic [LIVE_W-1:0]    r_live, n_live;
    logic [IDX_W-1:0]     r_free_head, n_free_head;
    logic [CNT_W-1:0]     r_free_cnt, n_free_cnt;
    logic [IDX_W-1:0]     r_pend_head, n_pend_head;
    logic [CNT_W-1:0]     r_pend_cnt, n_pend_cnt;
    logic                 r_rsp_valid, n_rsp_valid;

    // Payload of the request in flight and the response.
    gha_pkg::t_req        r_req, n_req;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [IDX_W-1:0]     r_ci, n_ci;
    logic                 r_grow, n_grow;
    logic                 r_full, n_full;
    gha_pkg::t_rsp        r_rsp, n_rsp;

    // Memory ports.
    logic                  slot_rd_en, slot_wr_en;
    logic [IDX_W-1:0]      slot_rd_addr, slot_wr_addr;
    gha_pkg::t_slot        slot_wr_data;
    logic [gha_pkg::SLOT_W-1:0] slot_rd_raw;
    gha_pkg::t_slot        slot_q;
    logic                  q_rd_en, q_wr_en;
    logic [IDX_W:0]        q_rd_addr, q_wr_addr;
    logic [IDX_W-1:0]      q_wr_data, q_rd_data;

    logic                  req_acc;
    logic                  out_free;
    logic                  hok;
    logic [IDX_W-1:0]      free_tail, pend_tail;
    logic                  free_full, pend_full;
    logic [GEN_W-1:0]      c_gen;

    gha_ram #(
        .DEPTH (gha_pkg::SLOT_COUNT),
        .WIDTH (gha_pkg::SLOT_W)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (slot_wr_en),
        .i_wr_addr (slot_wr_addr),
        .i_wr_data (slot_wr_data),
        .i_rd_en   (slot_rd_en),
        .i_rd_addr (slot_rd_addr),
        .o_rd_data (slot_rd_raw)
    );

    // Free queue in the lower half, pending queue in the upper half.
    gha_ram #(
        .DEPTH (2 * gha_pkg::SLOT_COUNT),
        .WIDTH (IDX_W)
    ) u_queue_ram (
        .i_clk     (i_clk),
        .i_wr_en   (q_wr_en),
        .i_wr_addr (q_wr_addr),
        .i_wr_data (q_wr_data),
        .i_rd_en   (q_rd_en),
        .i_rd_addr (q_rd_addr),
        .o_rd_data (q_rd_data)
    );

    assign slot_q      = gha_pkg::t_slot'(slot_rd_raw);
    assign o_req_stall = (r_state != gha_pkg::S_IDLE);
    assign req_acc     = i_req_valid && !o_req_stall;
    assign out_free    = !r_rsp_valid || !i_rsp_stall;
    assign free_tail   = r_free_head + r_free_cnt[IDX_W-1:0];
    assign pend_tail   = r_pend_head + r_pend_cnt[IDX_W-1:0];
    assign c_gen       = r_grow ? gha_pkg::GEN_FIRST : slot_q.gen;

    // A push to a full queue is dropped.
    assign free_full   = (r_free_cnt == CNT_W'(gha_pkg::SLOT_COUNT));
    assign pend_full   = (r_pend_cnt == CNT_W'(gha_pkg::SLOT_COUNT));

    // A handle is current when its slot was grown into and the generations agree.
    assign hok = ({1'b0, r_idx} < r_siu) && (slot_q.gen == r_req.slot_generation);

    // Sequencer: next state, memory accesses and response.
    always_comb begin
        n_state     = r_state;
        n_siu       = r_siu;
        n_live      = r_live;
        n_free_head = r_free_head;
        n_free_cnt  = r_free_cnt;
        n_pend_head = r_pend_head;
        n_pend_cnt  = r_pend_cnt;
        n_rsp_valid = r_rsp_valid && i_rsp_stall;
        n_req       = r_req;
        n_idx       = r_idx;
        n_ci        = r_ci;
        n_grow      = r_grow;
        n_full      = r_full;
        n_rsp       = r_rsp;

        slot_rd_en   = 1'b0;
        slot_rd_addr = r_idx;
        slot_wr_en   = 1'b0;
        slot_wr_addr = r_idx;
        slot_wr_data = '0;
        q_rd_en      = 1'b0;
        q_rd_addr    = {gha_pkg::Q_FREE, r_free_head};
        q_wr_en      = 1'b0;
        q_wr_addr    = {gha_pkg::Q_FREE, free_tail};
        q_wr_data    = r_idx;

        case (r_state)
            gha_pkg::S_IDLE: begin
                if (req_acc) begin
                    n_req   = i_req;
                    n_idx   = i_req.slot_index;
                    n_grow  = 1'b0;
                    n_full  = 1'b0;
                    n_state = gha_pkg::S_EXEC;
                    case (i_req.action)
                        gha_pkg::ACT_CREATE: begin
                            if (r_free_cnt != '0) begin
                                q_rd_en   = 1'b1;
                                q_rd_addr = {gha_pkg::Q_FREE, r_free_head};
                                n_state   = gha_pkg::S_POP_FREE;
                            end else if (r_siu < CNT_W'(gha_pkg::SLOT_COUNT)) begin
                                n_grow = 1'b1;
                                n_idx  = r_siu[IDX_W-1:0];
                            end else begin
                                n_full = 1'b1;
                            end
                        end
                        gha_pkg::ACT_ADD, gha_pkg::ACT_DESTROY,
                        gha_pkg::ACT_DESTROY_NOW, gha_pkg::ACT_CHECK: begin
                            slot_rd_en   = 1'b1;
                            slot_rd_addr = i_req.slot_index;
                        end
                        gha_pkg::ACT_REFRESH: begin
                            if (r_pend_cnt != '0) begin
                                n_state = gha_pkg::S_REF_RD;
                            end
                        end
                        gha_pkg::ACT_CLEAR: begin
                            // Both queues are emptied and rebuilt while walking the slots.
                            n_free_head = '0;
                            n_free_cnt  = '0;
                            n_pend_head = '0;
                            n_pend_cnt  = '0;
                            n_live      = '0;
                            n_ci        = '0;
                            if (r_siu != '0) begin
                                n_state = gha_pkg::S_CLR_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            gha_pkg::S_POP_FREE: begin
                // The head of the free list is the slot to hand out.
                n_idx        = q_rd_data;
                slot_rd_en   = 1'b1;
                slot_rd_addr = q_rd_data;
                n_free_head  = r_free_head + IDX_W'(1);
                n_free_cnt   = r_free_cnt - CNT_W'(1);
                n_state      = gha_pkg::S_EXEC;
            end

            gha_pkg::S_REF_RD: begin
                q_rd_en     = 1'b1;
                q_rd_addr   = {gha_pkg::Q_PEND, r_pend_head};
                n_pend_head = r_pend_head + IDX_W'(1);
                n_pend_cnt  = r_pend_cnt - CNT_W'(1);
                n_state     = gha_pkg::S_REF_WR;
            end

            gha_pkg::S_REF_WR: begin
                // The popped slot is lost if the free list is already full.
                q_wr_addr = {gha_pkg::Q_FREE, free_tail};
                q_wr_data = q_rd_data;
                if (!free_full) begin
                    q_wr_en    = 1'b1;
                    n_free_cnt = r_free_cnt + CNT_W'(1);
                end
                n_state = (r_pend_cnt != '0) ? gha_pkg::S_REF_RD : gha_pkg::S_EXEC;
            end

            gha_pkg::S_CLR_RD: begin
                slot_rd_en   = 1'b1;
                slot_rd_addr = r_ci;
                n_state      = gha_pkg::S_CLR_WR;
            end

            gha_pkg::S_CLR_WR: begin
                // New generation and empty mask; the slot goes back on the free list in order.
                slot_wr_en        = 1'b1;
                slot_wr_addr      = r_ci;
                slot_wr_data.gen  = gha_pkg::gen_next(slot_q.gen);
                slot_wr_data.mask = '0;
                q_wr_en           = 1'b1;
                q_wr_addr         = {gha_pkg::Q_FREE, free_tail};
                q_wr_data         = r_ci;
                n_free_cnt        = r_free_cnt + CNT_W'(1);
                n_ci              = r_ci + IDX_W'(1);
                if (({1'b0, r_ci} + CNT_W'(1)) == r_siu) begin
                    n_state = gha_pkg::S_EXEC;
                end else begin
                    n_state = gha_pkg::S_CLR_RD;
                end
            end

            gha_pkg::S_EXEC: begin
                // Side effects and the response happen together, once the output is free.
                if (out_free) begin
                    n_rsp.status         = gha_pkg::ST_OK;
                    n_rsp.out_index      = '0;
                    n_rsp.out_generation = '0;
                    n_rsp.handle_valid   = 1'b0;
                    case (r_req.action)
                        gha_pkg::ACT_CREATE: begin
                            if (r_full) begin
                                n_rsp.status = gha_pkg::ST_NOFREE;
                            end else begin
                                slot_wr_en           = 1'b1;
                                slot_wr_addr         = r_idx;
                                slot_wr_data.gen     = c_gen;
                                slot_wr_data.mask    = r_req.initial_mask & gha_pkg::COMP_MASK;
                                n_live               = r_live + LIVE_W'(1);
                                n_rsp.out_index      = r_idx;
                                n_rsp.out_generation = c_gen;
                                if (r_grow) begin
                                    n_siu = r_siu + CNT_W'(1);
                                end
                            end
                        end
                        gha_pkg::ACT_ADD: begin
                            if (!hok || ({1'b0, r_req.component_type} >= gha_pkg::COMP_LIMIT))
                            begin
                                n_rsp.status = gha_pkg::ST_STALE;
                            end else begin
                                slot_wr_en        = 1'b1;
                                slot_wr_addr      = r_idx;
                                slot_wr_data.gen  = slot_q.gen;
                                slot_wr_data.mask = slot_q.mask
                                    | (gha_pkg::MASK_W'(1) << r_req.component_type);
                            end
                        end
                        gha_pkg::ACT_DESTROY, gha_pkg::ACT_DESTROY_NOW: begin
                            if (!hok) begin
                                n_rsp.status = gha_pkg::ST_STALE;
                            end else begin
                                slot_wr_en        = 1'b1;
                                slot_wr_addr      = r_idx;
                                slot_wr_data.gen  = gha_pkg::gen_next(slot_q.gen);
                                slot_wr_data.mask = '0;
                                q_wr_data         = r_idx;
                                if (r_req.action == gha_pkg::ACT_DESTROY) begin
                                    q_wr_addr = {gha_pkg::Q_PEND, pend_tail};
                                    if (!pend_full) begin
                                        q_wr_en    = 1'b1;
                                        n_pend_cnt = r_pend_cnt + CNT_W'(1);
                                    end
                                end else begin
                                    q_wr_addr = {gha_pkg::Q_FREE, free_tail};
                                    if (!free_full) begin
                                        q_wr_en    = 1'b1;
                                        n_free_cnt = r_free_cnt + CNT_W'(1);
                                    end
                                end
                                if (r_live != '0) begin
                                    n_live = r_live - LIVE_W'(1);
                                end
                            end
                        end
                        gha_pkg::ACT_CHECK: begin
                            n_rsp.handle_valid = hok;
                        end
                        default: begin
                        end
                    endcase
                    n_rsp.live_count = n_live[CNT_W-1:0];
                    n_rsp_valid      = 1'b1;
                    n_state          = gha_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = gha_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gha_pkg::S_IDLE;
            r_siu       <= '0;
            r_live      <= '0;
            r_free_head <= '0;
            r_free_cnt  <= '0;
            r_pend_head <= '0;
            r_pend_cnt  <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_siu       <= n_siu;
            r_live      <= n_live;
            r_free_head <= n_free_head;
            r_free_cnt  <= n_free_cnt;
            r_pend_head <= n_pend_head;
            r_pend_cnt  <= n_pend_cnt;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_idx  <= n_idx;
        r_ci   <= n_ci;
        r_grow <= n_grow;
        r_full <= n_full;
        r_rsp  <= n_rsp;
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // Neither queue ever holds more entries than there are slots.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_free_cnt <= CNT_W'(gha_pkg::SLOT_COUNT)) &&
        (r_pend_cnt <= CNT_W'(gha_pkg::SLOT_COUNT)))
        else $error("queue count exceeds the slot count");

    // The grown slot count never shrinks.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_siu >= $past(r_siu)))
        else $error("grown slot count decreased");

    // The clear walk stays inside the grown slots.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gha_pkg::S_CLR_WR) |-> ({1'b0, r_ci} < r_siu))
        else $error("clear walk passed the grown slots");

    // A response is only produced by the execute step.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp_valid) |-> $past(r_state == gha_pkg::S_EXEC))
        else $error("response appeared outside the execute step");

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the generational handle allocator, with a request predictor.
module testbench;

    // Action code that the block must ignore.
    localparam logic [2:0] ACT_UNUSED = 3'd7;
    // Cycles without any accepted request or response before the run is declared hung.
    localparam int QUIET_LIMIT = 20000;
    // Number of retired handles kept for stale-handle requests.
    localparam int STALE_KEEP = 64;

    typedef struct packed {
        logic [gha_pkg::IDX_W-1:0] idx;
        logic [gha_pkg::GEN_W-1:0] gen;
    } t_handle;

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          req_valid = 1'b0;
    gha_pkg::t_req req_bus   = '0;
    logic          rsp_stall = 1'b0;
    logic          req_stall;
    logic          rsp_valid;
    gha_pkg::t_rsp rsp_bus;

    // Predicted allocator state.
    logic [gha_pkg::GEN_W-1:0] gen_of [gha_pkg::SLOT_COUNT];
    logic [gha_pkg::IDX_W-1:0] free_list [$];
    logic [gha_pkg::IDX_W-1:0] pending_list [$];
    int               grown;
    int               live;

    // Responses still owed by the block, oldest first.
    gha_pkg::t_rsp    expected_rsps [$];
    gha_pkg::t_rsp    want_rsp;

    // Handles handed out by the block, used to build meaningful requests.
    t_handle          live_handles [$];
    t_handle          stale_handles [$];

    // Traffic shaping and bookkeeping.
    bit               idle_on = 1'b1;
    int               burst_left = 0;
    int               stall_span = 0;
    logic [1:0]       stall_mode = 2'd0;
    logic             stall_now;
    int               quiet_cycles = 0;
    int               errors = 0;
    int               requests_sent = 0;
    int               rsps_checked = 0;
    int               refused_creates = 0;

    generational_handle_allocator uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .o_req_stall (req_stall),
        .i_req       (req_bus),
        .o_rsp_valid (rsp_valid),
        .i_rsp_stall (rsp_stall),
        .o_rsp       (rsp_bus)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Generation that follows g; zero is skipped on wrap.
    function automatic logic [gha_pkg::GEN_W-1:0] next_generation(
        input logic [gha_pkg::GEN_W-1:0] g);
        return (g == '1) ? gha_pkg::GEN_W'(1) : g + gha_pkg::GEN_W'(1);
    endfunction

    function automatic void push_free(input logic [gha_pkg::IDX_W-1:0] s);
        if (free_list.size() < gha_pkg::SLOT_COUNT) free_list.insert(free_list.size(), s);
    endfunction

    // Apply one request to the predicted state and return the response it should produce.
    task automatic compute_response(input gha_pkg::t_req req, output gha_pkg::t_rsp rsp);
        logic [gha_pkg::IDX_W-1:0] slot;
        bit               handle_ok;
        rsp = '0;
        handle_ok = (int'(req.slot_index) < grown) &&
                    (gen_of[req.slot_index] == req.slot_generation);
        case (req.action)
            gha_pkg::ACT_CREATE: begin
                if (free_list.size() > 0 || grown < gha_pkg::SLOT_COUNT) begin
                    if (free_list.size() > 0) begin
                        slot = free_list[0];
                        free_list.delete(0);
                    end else begin
                        slot = gha_pkg::IDX_W'(grown);
                        grown++;
                    end
                    live++;
                    rsp.out_index      = slot;
                    rsp.out_generation = gen_of[slot];
                end else begin
                    rsp.status = gha_pkg::ST_NOFREE;
                end
            end
            gha_pkg::ACT_ADD: begin
                if (!handle_ok || int'(req.component_type) >= gha_pkg::COMP_TYPES) begin
                    rsp.status = gha_pkg::ST_STALE;
                end
            end
            gha_pkg::ACT_DESTROY, gha_pkg::ACT_DESTROY_NOW: begin
                if (!handle_ok) begin
                    rsp.status = gha_pkg::ST_STALE;
                end else begin
                    gen_of[req.slot_index] = next_generation(gen_of[req.slot_index]);
                    if (req.action == gha_pkg::ACT_DESTROY) begin
                        if (pending_list.size() < gha_pkg::SLOT_COUNT) begin
                            pending_list.insert(pending_list.size(), req.slot_index);
                        end
                    end else begin
                        push_free(req.slot_index);
                    end
                    if (live > 0) live--;
                end
            end
            gha_pkg::ACT_REFRESH: begin
                while (pending_list.size() > 0) begin
                    push_free(pending_list[0]);
                    pending_list.delete(0);
                end
            end
            gha_pkg::ACT_CHECK: begin
                rsp.handle_valid = handle_ok;
            end
            gha_pkg::ACT_CLEAR: begin
                free_list.delete();
                pending_list.delete();
                for (int s = 0; s < grown; s++) begin
                    gen_of[s] = next_generation(gen_of[s]);
                    push_free(gha_pkg::IDX_W'(s));
                end
                live = 0;
            end
            default: begin
            end
        endcase
        rsp.live_count = gha_pkg::CNT_W'(live);
    endtask

    function automatic gha_pkg::t_req make_request(input gha_pkg::t_action act,
                                                   input logic [gha_pkg::IDX_W-1:0] idx,
                                                   input logic [gha_pkg::GEN_W-1:0] gen,
                                                   input logic [gha_pkg::MASK_W-1:0] mask,
                                                   input logic [gha_pkg::CTYPE_W-1:0] ctype);
        gha_pkg::t_req r;
        r.action          = act;
        r.slot_index      = idx;
        r.slot_generation = gen;
        r.initial_mask    = mask;
        r.component_type  = ctype;
        return r;
    endfunction

    // Drive one request, wait until the block takes it, then record what it should answer.
    task automatic send_request(input gha_pkg::t_req req);
        gha_pkg::t_rsp want;
        t_handle       h;
        int            gap;
        int            pos;
        pos = -1;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = 0;
            if (idle_on) gap = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 30)
                                                            : $urandom_range(0, 4);
            if (gap > 0) begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_valid <= 1'b1;
        req_bus   <= req;
        do @(posedge clk); while (req_stall);

        compute_response(req, want);
        expected_rsps.insert(expected_rsps.size(), want);
        requests_sent++;
        if (want.status == gha_pkg::ST_NOFREE) refused_creates++;

        // Keep the list of handles in step with the block.
        case (req.action)
            gha_pkg::ACT_CREATE: begin
                if (want.status == gha_pkg::ST_OK) begin
                    h.idx = want.out_index;
                    h.gen = want.out_generation;
                    live_handles.insert(live_handles.size(), h);
                end
            end
            gha_pkg::ACT_DESTROY, gha_pkg::ACT_DESTROY_NOW: begin
                if (want.status == gha_pkg::ST_OK) begin
                    foreach (live_handles[k]) if (live_handles[k].idx == req.slot_index) pos = k;
                    if (pos >= 0) live_handles.delete(pos);
                    h.idx = req.slot_index;
                    h.gen = req.slot_generation;
                    stale_handles.insert(stale_handles.size(), h);
                end
            end
            gha_pkg::ACT_CLEAR: begin
                foreach (live_handles[k]) stale_handles.insert(stale_handles.size(),
                                                               live_handles[k]);
                live_handles.delete();
            end
            default: begin
            end
        endcase
        while (stale_handles.size() > STALE_KEEP) stale_handles.delete(0);
    endtask

    // Mostly requests built on real handles, plus stale handles, forged handles and noise.
    function automatic gha_pkg::t_req random_request();
        gha_pkg::t_req r;
        t_handle       h;
        int            pick;
        r = make_request(gha_pkg::ACT_CREATE,
                         gha_pkg::IDX_W'($urandom_range(0, gha_pkg::SLOT_COUNT - 1)),
                         gha_pkg::GEN_W'($urandom), {$urandom, $urandom},
                         gha_pkg::CTYPE_W'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            r.action = gha_pkg::ACT_CREATE;
        end else if (pick < 36) begin
            r.action = gha_pkg::ACT_REFRESH;
        end else if (pick < 37) begin
            r.action = gha_pkg::ACT_CLEAR;
        end else if (pick < 39) begin
            r.action = gha_pkg::t_action'(ACT_UNUSED);
        end else if (pick < 49) begin
            r.action = gha_pkg::t_action'(3'($urandom_range(int'(gha_pkg::ACT_ADD),
                                                            int'(gha_pkg::ACT_CHECK))));
            if (grown > 0 && $urandom_range(0, 1)) begin
                r.slot_index = gha_pkg::IDX_W'($urandom_range(0, grown - 1));
                if ($urandom_range(0, 3) == 0) r.slot_generation = gen_of[r.slot_index];
            end
        end else if (live_handles.size() > 0 || stale_handles.size() > 0) begin
            if (live_handles.size() == 0 ||
                (stale_handles.size() > 0 && $urandom_range(0, 4) == 0)) begin
                h = stale_handles[$urandom_range(0, stale_handles.size() - 1)];
            end else begin
                h = live_handles[$urandom_range(0, live_handles.size() - 1)];
            end
            r.slot_index      = h.idx;
            r.slot_generation = h.gen;
            if (pick < 65)      r.action = gha_pkg::ACT_ADD;
            else if (pick < 76) r.action = gha_pkg::ACT_DESTROY;
            else if (pick < 84) r.action = gha_pkg::ACT_DESTROY_NOW;
            else                r.action = gha_pkg::ACT_CHECK;
        end
        return r;
    endfunction

    // Step slot 0 through several generations by clear and by immediate destroy.
    task automatic test_generation_steps();
        idle_on = 1'b0;
        send_request(make_request(gha_pkg::ACT_CREATE, '0, '0, '1, '0));
        repeat (8) send_request(make_request(gha_pkg::ACT_CLEAR, '0, '0, '0, '0));
        send_request(make_request(gha_pkg::ACT_CREATE, '1, '1, '0, '1));
        send_request(make_request(gha_pkg::ACT_DESTROY_NOW, '0, gen_of[0], '0, '0));
        send_request(make_request(gha_pkg::ACT_CHECK, '0, gen_of[0], '0, '0));
        send_request(make_request(gha_pkg::ACT_CLEAR, '0, '0, '0, '0));
        idle_on = 1'b1;
    endtask

    // Short hand-picked sequence: every action, field extremes and bad handles.
    task automatic test_directed_cases();
        logic [gha_pkg::GEN_W-1:0] old_gen;
        send_request(make_request(gha_pkg::ACT_CREATE, '0, '0, '0, '0));
        send_request(make_request(gha_pkg::ACT_CREATE, '1, '1, '1, '1));
        send_request(make_request(gha_pkg::ACT_CREATE, '0, '0, 64'h8000_0000_0000_0001, '0));
        send_request(make_request(gha_pkg::ACT_ADD, gha_pkg::IDX_W'(1), gen_of[1], '0,
                                  gha_pkg::CTYPE_W'(0)));
        send_request(make_request(gha_pkg::ACT_ADD, gha_pkg::IDX_W'(0), gen_of[0], '0, '1));
        // Wrong generation, then an index that was never grown into.
        send_request(make_request(gha_pkg::ACT_ADD, gha_pkg::IDX_W'(1),
                                  gen_of[1] + gha_pkg::GEN_W'(1), '0, gha_pkg::CTYPE_W'(5)));
        send_request(make_request(gha_pkg::ACT_ADD, '1, gen_of[gha_pkg::SLOT_COUNT-1], '0,
                                  gha_pkg::CTYPE_W'(7)));
        send_request(make_request(gha_pkg::ACT_CHECK, gha_pkg::IDX_W'(1), gen_of[1], '0, '0));
        send_request(make_request(gha_pkg::ACT_CHECK, '1, '1, '0, '0));
        send_request(make_request(gha_pkg::ACT_CHECK, '0, '0, '0, '0));
        old_gen = gen_of[1];
        send_request(make_request(gha_pkg::ACT_DESTROY, gha_pkg::IDX_W'(1), old_gen, '0, '0));
        send_request(make_request(gha_pkg::ACT_CHECK, gha_pkg::IDX_W'(1), old_gen, '0, '0));
        send_request(make_request(gha_pkg::ACT_DESTROY, gha_pkg::IDX_W'(1), old_gen, '0, '0));
        send_request(make_request(gha_pkg::ACT_DESTROY_NOW, gha_pkg::IDX_W'(2), gen_of[2],
                                  '0, '0));
        send_request(make_request(gha_pkg::ACT_DESTROY_NOW, '1, gha_pkg::GEN_W'(1), '0, '0));
        // Slot 2 comes back at once; slot 1 only after a refresh.
        send_request(make_request(gha_pkg::ACT_CREATE, '0, '0, {$urandom, $urandom}, '0));
        send_request(make_request(gha_pkg::ACT_CREATE, '0, '0, {$urandom, $urandom}, '0));
        send_request(make_request(gha_pkg::ACT_REFRESH, '0, '0, '0, '0));
        send_request(make_request(gha_pkg::ACT_CREATE, '0, '0, {$urandom, $urandom}, '0));
        send_request(make_request(gha_pkg::ACT_REFRESH, '1, '1, '1, '1));
        send_request(make_request(gha_pkg::t_action'(ACT_UNUSED), '1, '1, '1, '1));
        send_request(make_request(gha_pkg::ACT_CLEAR, '0, '0, '0, '0));
    endtask

    task automatic test_random_traffic(input int count);
        repeat (count) send_request(random_request());
    endtask

    // Fill the whole table, then probe the full condition and recovery from it.
    task automatic test_slot_exhaustion();
        logic [gha_pkg::GEN_W-1:0] last_gen;
        while (free_list.size() > 0 || grown < gha_pkg::SLOT_COUNT) begin
            send_request(make_request(gha_pkg::ACT_CREATE, gha_pkg::IDX_W'($urandom),
                                      gha_pkg::GEN_W'($urandom), {$urandom, $urandom},
                                      gha_pkg::CTYPE_W'($urandom)));
        end
        send_request(make_request(gha_pkg::ACT_CREATE, '0, '0, '1, '0));
        last_gen = gen_of[gha_pkg::SLOT_COUNT-1];
        send_request(make_request(gha_pkg::ACT_CHECK, '1, last_gen, '0, '0));
        send_request(make_request(gha_pkg::ACT_ADD, '1, last_gen, '0, '1));
        send_request(make_request(gha_pkg::ACT_DESTROY, '1, last_gen, '0, '0));
        // A pending slot is not yet reusable.
        send_request(make_request(gha_pkg::ACT_CREATE, '0, '0, '0, '0));
        send_request(make_request(gha_pkg::ACT_REFRESH, '0, '0, '0, '0));
        send_request(make_request(gha_pkg::ACT_CREATE, '0, '0, '0, '0));
        send_request(make_request(gha_pkg::ACT_CLEAR, '0, '0, '0, '0));
    endtask

    // Response stall pattern: modes from never to mostly stalled, each held for a while.
    always @(posedge clk) begin
        if (stall_span == 0) begin
            stall_mode <= 2'($urandom_range(0, 3));
            stall_span <= $urandom_range(20, 300);
        end else begin
            stall_span <= stall_span - 1;
        end
        case (stall_mode)
            2'd0:    stall_now = 1'b0;
            2'd1:    stall_now = ($urandom_range(0, 3) == 0);
            2'd2:    stall_now = ($urandom_range(0, 1) == 0);
            default: stall_now = ($urandom_range(0, 9) < 8);
        endcase
        rsp_stall <= idle_on && stall_now;
    end

    // Compare each accepted response with the oldest expectation.
    always @(posedge clk) begin
        if (rst_n && rsp_valid && !rsp_stall) begin
            rsps_checked++;
            if (expected_rsps.size() == 0) begin
                $error("response with no request outstanding");
                errors++;
            end else begin
                want_rsp = expected_rsps[0];
                expected_rsps.delete(0);
                if (rsp_bus.status !== want_rsp.status) begin
                    $error("status: expected %0d, got %0d", want_rsp.status, rsp_bus.status);
                    errors++;
                end
                if (rsp_bus.out_index !== want_rsp.out_index) begin
                    $error("out_index: expected %0d, got %0d",
                           want_rsp.out_index, rsp_bus.out_index);
                    errors++;
                end
                if (rsp_bus.out_generation !== want_rsp.out_generation) begin
                    $error("out_generation: expected %0d, got %0d",
                           want_rsp.out_generation, rsp_bus.out_generation);
                    errors++;
                end
                if (rsp_bus.handle_valid !== want_rsp.handle_valid) begin
                    $error("handle_valid: expected %0d, got %0d",
                           want_rsp.handle_valid, rsp_bus.handle_valid);
                    errors++;
                end
                if (rsp_bus.live_count !== want_rsp.live_count) begin
                    $error("live_count: expected %0d, got %0d",
                           want_rsp.live_count, rsp_bus.live_count);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles in which neither channel moves.
    always @(posedge clk) begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        for (int s = 0; s < gha_pkg::SLOT_COUNT; s++) gen_of[s] = gha_pkg::GEN_FIRST;
        grown = 0;
        live  = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_generation_steps();
        test_directed_cases();
        test_random_traffic(120);
        test_slot_exhaustion();
        test_random_traffic(40);

        // Let the last responses drain, then give the block time to misbehave.
        req_valid <= 1'b0;
        while (expected_rsps.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);

        $display("tb: %0d requests sent, %0d responses checked, %0d errors", requests_sent,
                 rsps_checked, errors);
        $display("tb: exercised every action, %0d of %0d slots grown, %0d refused creates",
                 grown, gha_pkg::SLOT_COUNT, refused_creates);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/gha_pkg.sv
hw/rtl/gha_ram.sv
hw/rtl/generational_handle_allocator.sv
tb/sv/testbench.sv
